// ----- rtl/dmvm_pkg.sv -----
// Shared types and constants for the dequantizing matrix-vector MAC.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dmvm_pkg;

  // Operation codes of the input channel
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_WEIGHT = 1'b1
  } op_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SCALE = 3'd4;

  localparam int CFG_DATA_W = 16;
  localparam int LEN_REG_W  = 11;
  localparam int VEC_IDX_W  = 10;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 48;
  localparam int ROW_NUM_W  = 10;

  // Dequantization settings seen by the datapath
  typedef struct packed {
    logic               mode;
    logic signed [15:0] base;
    logic [15:0]        scale;
  } dq_cfg_t;

  // Per-weight bookkeeping that travels with the item down the pipeline
  typedef struct packed {
    logic                 eor;      // last weight of its row
    logic                 last;     // row is the final one of the pass
    logic [ROW_NUM_W-1:0] row_num;
  } row_tag_t;

endpackage

// ----- rtl/dequant_matrix_vector_mac.sv -----
// Top level of the dequantizing matrix-vector MAC: configuration registers,
// row/column sequencing, and the store and MAC pipeline.
// Depends on dmvm_pkg, dmvm_vec_store and dmvm_mac.
`timescale 1ns / 1ps

// Usage:
// - Configuration: cfg_we writes cfg_data into register cfg_index (0 mode, 1 row
//   length, 2 row count, 3 base, 4 scale); only while idle, up to the user.
// - Input channel (in_valid/in_ready): op = 0 loads vec_value at vec_index
//   into the vector store; op = 1 delivers the next weight of the row-major
//   stream. Load the entries a row uses before streaming its weights.
// - Output channel (out_valid/out_ready): one item per completed row with the
//   saturated Q32.16 sum, the row number, a last-row mark and a saturation flag.
// - Throughput: one input item per cycle while in_ready is high, loads and
//   weights alike; set by the single read and single write port of the vector
//   store and the fully pipelined dequant/multiply/accumulate path.
// - Path: after its last weight is accepted, the row item passes the three
//   pipeline stages, then the output register.
// - Stall: a finished row waits in the output register; the pipeline keeps
//   accepting weights until a second row end reaches the accumulator while
//   the first is still untaken, then in_ready drops until out_ready.
// - Reset (rst, synchronous): registers take their defaults, the row and
//   column counters and accumulator clear. The vector store is not cleared;
//   entries must be loaded before use.

module dequant_matrix_vector_mac #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [dmvm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [dmvm_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    op,
  input  logic [dmvm_pkg::VEC_IDX_W-1:0]          vec_index,
  input  logic signed [dmvm_pkg::DATA_W-1:0]      vec_value,
  input  logic signed [dmvm_pkg::DATA_W-1:0]      weight_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [dmvm_pkg::ACC_W-1:0]       row_sum,
  output logic [dmvm_pkg::ROW_NUM_W-1:0]          row_number,
  output logic                                    last_row,
  output logic                                    saturated
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLEN_W = ($clog2(MAX_COLS + 1) > dmvm_pkg::LEN_REG_W)
                          ? $clog2(MAX_COLS + 1) : dmvm_pkg::LEN_REG_W;
  localparam int RLEN_W = ($clog2(MAX_ROWS + 1) > dmvm_pkg::LEN_REG_W)
                          ? $clog2(MAX_ROWS + 1) : dmvm_pkg::LEN_REG_W;
  localparam logic [CLEN_W-1:0] COLS_TOP = CLEN_W'(MAX_COLS);
  localparam logic [RLEN_W-1:0] ROWS_TOP = RLEN_W'(MAX_ROWS);

  // configuration registers
  logic                                  weight_mode;
  logic [dmvm_pkg::LEN_REG_W-1:0]        row_length;
  logic [dmvm_pkg::LEN_REG_W-1:0]        row_count;
  logic signed [dmvm_pkg::DATA_W-1:0]    weight_base;
  logic [dmvm_pkg::DATA_W-1:0]           weight_scale;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [CLEN_W-1:0] cols_eff;
  logic [RLEN_W-1:0] rows_eff;
  logic              col_end;
  logic              row_end;
  logic              accept;
  logic              load_acc;
  logic              weight_acc;
  logic              stall;
  dmvm_pkg::row_tag_t tag;
  dmvm_pkg::dq_cfg_t  dq_cfg;
  logic signed [dmvm_pkg::DATA_W-1:0] rd_data;

  assign in_ready   = !stall;
  assign accept     = in_valid && in_ready;
  assign load_acc   = accept && (dmvm_pkg::op_t'(op) == dmvm_pkg::OP_LOAD);
  assign weight_acc = accept && (dmvm_pkg::op_t'(op) == dmvm_pkg::OP_WEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode  <= 1'b0;
      row_length   <= dmvm_pkg::LEN_REG_W'(1024);
      row_count    <= dmvm_pkg::LEN_REG_W'(1);
      weight_base  <= '0;
      weight_scale <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        dmvm_pkg::REG_WEIGHT_MODE:  weight_mode  <= cfg_data[0];
        dmvm_pkg::REG_ROW_LENGTH:   row_length   <= cfg_data[dmvm_pkg::LEN_REG_W-1:0];
        dmvm_pkg::REG_ROW_COUNT:    row_count    <= cfg_data[dmvm_pkg::LEN_REG_W-1:0];
        dmvm_pkg::REG_WEIGHT_BASE:  weight_base  <= cfg_data;
        dmvm_pkg::REG_WEIGHT_SCALE: weight_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (row_length == '0) begin
      cols_eff = CLEN_W'(1);
    end else if (CLEN_W'(row_length) > COLS_TOP) begin
      cols_eff = COLS_TOP;
    end else begin
      cols_eff = CLEN_W'(row_length);
    end
    if (row_count == '0) begin
      rows_eff = RLEN_W'(1);
    end else if (RLEN_W'(row_count) > ROWS_TOP) begin
      rows_eff = ROWS_TOP;
    end else begin
      rows_eff = RLEN_W'(row_count);
    end
    col_end = ((CLEN_W+1)'(col) + (CLEN_W+1)'(1)) >= (CLEN_W+1)'(cols_eff);
    row_end = ((RLEN_W+1)'(row) + (RLEN_W+1)'(1)) >= (RLEN_W+1)'(rows_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (weight_acc) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_comb begin
    tag.eor     = col_end;
    tag.last    = row_end;
    tag.row_num = dmvm_pkg::ROW_NUM_W'(row);
    dq_cfg.mode  = weight_mode;
    dq_cfg.base  = weight_base;
    dq_cfg.scale = weight_scale;
  end

  dmvm_vec_store #(
    .DEPTH (MAX_COLS)
  ) u_store (
    .clk      (clk),
    .wr_en    (load_acc),
    .wr_index (vec_index),
    .wr_data  (vec_value),
    .rd_en    (weight_acc),
    .rd_addr  (col),
    .rd_data  (rd_data)
  );

  dmvm_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .issue        (weight_acc),
    .weight_value (weight_value),
    .tag          (tag),
    .cfg          (dq_cfg),
    .rd_data      (rd_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .row_sum      (row_sum),
    .row_number   (row_number),
    .last_row     (last_row),
    .saturated    (saturated),
    .stall        (stall)
  );

`ifndef SYNTHESIS
  a_col_wraps: assert property (@(posedge clk) disable iff (rst)
    weight_acc && col_end |=> col == '0)
    else $error("column did not wrap at row end");

  a_col_steps: assert property (@(posedge clk) disable iff (rst)
    weight_acc && !col_end |=> col == $past(col) + COL_W'(1) && row == $past(row))
    else $error("column did not advance within row");

  a_no_accept_in_stall: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(col) && $stable(row))
    else $error("counters moved while stalled");
`endif

endmodule

// ----- rtl/dmvm_vec_store.sv -----
// Input vector store: synchronous single-write, single-read memory.
// Uses dmvm_pkg for data and index widths.
`timescale 1ns / 1ps

module dmvm_vec_store #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [dmvm_pkg::VEC_IDX_W-1:0]      wr_index,
  input  logic signed [dmvm_pkg::DATA_W-1:0]  wr_data,
  input  logic                                rd_en,
  input  logic [AW-1:0]                       rd_addr,
  output logic signed [dmvm_pkg::DATA_W-1:0]  rd_data
);

  logic signed [dmvm_pkg::DATA_W-1:0] mem [DEPTH];
  logic [dmvm_pkg::VEC_IDX_W-1:0] idx_red;
  logic [AW-1:0] wr_addr;

  // Index modulo DEPTH by restoring subtraction of DEPTH*2^k; only the
  // steps whose subtrahend fits in the index range exist.
  always_comb begin
    idx_red = wr_index;
    for (int k = dmvm_pkg::VEC_IDX_W - 1; k >= 0; k--) begin
      if ((longint'(DEPTH) << k) < (longint'(1) << dmvm_pkg::VEC_IDX_W)) begin
        if (idx_red >= dmvm_pkg::VEC_IDX_W'(longint'(DEPTH) << k)) begin
          idx_red = idx_red - dmvm_pkg::VEC_IDX_W'(longint'(DEPTH) << k);
        end
      end
    end
    wr_addr = AW'(idx_red);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/dmvm_mac.sv -----
// Dequantize, multiply and saturating accumulate pipeline with output register.
// Uses dmvm_pkg types; dmvm_vec_store gives vector data in the cycle after issue.
`timescale 1ns / 1ps

module dmvm_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  issue,
  input  logic signed [dmvm_pkg::DATA_W-1:0]    weight_value,
  input  dmvm_pkg::row_tag_t                    tag,
  input  dmvm_pkg::dq_cfg_t                     cfg,
  input  logic signed [dmvm_pkg::DATA_W-1:0]    rd_data,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [dmvm_pkg::ACC_W-1:0]     row_sum,
  output logic [dmvm_pkg::ROW_NUM_W-1:0]        row_number,
  output logic                                  last_row,
  output logic                                  saturated,
  output logic                                  stall
);

  // stage 1: scale * code
  logic                               s1_valid;
  logic                               s1_mode;
  logic signed [dmvm_pkg::DATA_W-1:0] s1_raw;
  logic [23:0]                        s1_sprod;
  dmvm_pkg::row_tag_t                 s1_tag;
  // stage 2: weight and vector entry
  logic                               s2_valid;
  logic signed [dmvm_pkg::DATA_W-1:0] s2_w;
  logic signed [dmvm_pkg::DATA_W-1:0] s2_x;
  logic                               s2_sat;
  dmvm_pkg::row_tag_t                 s2_tag;
  // stage 3: product
  logic                               s3_valid;
  logic signed [dmvm_pkg::PROD_W-1:0] s3_prod;
  logic                               s3_sat;
  dmvm_pkg::row_tag_t                 s3_tag;
  // accumulator
  logic signed [dmvm_pkg::ACC_W-1:0]  acc;
  logic                               sat_seen;

  logic signed [25:0]                 t_dq;
  logic signed [21:0]                 w_wide;
  logic                               w_hi;
  logic                               w_lo;
  logic signed [dmvm_pkg::DATA_W-1:0] w_dq;
  logic signed [dmvm_pkg::ACC_W:0]    sum;
  logic signed [dmvm_pkg::ACC_W-1:0]  acc_next;
  logic                               acc_ovf;
  logic                               emit;

  assign stall = s3_valid && s3_tag.eor && out_valid && !out_ready;
  assign emit  = s3_valid && s3_tag.eor && !stall;

  // Dequant: floor((base*16 + scale*code + 8) / 16), clamped to Q8.8
  always_comb begin
    t_dq   = {{6{cfg.base[15]}}, cfg.base, 4'b0000} + $signed({2'b00, s1_sprod}) + 26'sd8;
    w_wide = t_dq[25:4];
    w_hi   = !w_wide[21] && (|w_wide[20:15]);
    w_lo   = w_wide[21] && !(&w_wide[20:15]);
    if (w_hi) begin
      w_dq = 16'sh7FFF;
    end else if (w_lo) begin
      w_dq = -16'sh8000;
    end else begin
      w_dq = w_wide[15:0];
    end
  end

  always_comb begin
    sum     = {acc[dmvm_pkg::ACC_W-1], acc}
            + {{(dmvm_pkg::ACC_W + 1 - dmvm_pkg::PROD_W){s3_prod[dmvm_pkg::PROD_W-1]}}, s3_prod};
    acc_ovf = sum[dmvm_pkg::ACC_W] != sum[dmvm_pkg::ACC_W-1];
    if (acc_ovf) begin
      acc_next = sum[dmvm_pkg::ACC_W] ? {1'b1, {(dmvm_pkg::ACC_W-1){1'b0}}}
                                      : {1'b0, {(dmvm_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_next = sum[dmvm_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_mode  <= cfg.mode;
      s1_raw   <= weight_value;
      s1_sprod <= cfg.scale * weight_value[7:0];
      s1_tag   <= tag;
      s2_w     <= s1_mode ? w_dq : s1_raw;
      s2_x     <= rd_data;
      s2_sat   <= s1_mode && (w_hi || w_lo);
      s2_tag   <= s1_tag;
      s3_prod  <= s2_w * s2_x;
      s3_sat   <= s2_sat;
      s3_tag   <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      sat_seen <= 1'b0;
    end else if (s3_valid && !stall) begin
      if (s3_tag.eor) begin
        acc      <= '0;
        sat_seen <= 1'b0;
      end else begin
        acc      <= acc_next;
        sat_seen <= sat_seen || acc_ovf || s3_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row_sum    <= acc_next;
      row_number <= s3_tag.row_num;
      last_row   <= s3_tag.last;
      saturated  <= sat_seen || acc_ovf || s3_sat;
    end
  end

`ifndef SYNTHESIS
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid && (acc == '0) && !sat_seen)
    else $error("accumulator not cleared after row result");

  a_stall_holds_acc: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(acc) && s3_valid)
    else $error("accumulator moved while pipeline stalled");

  a_stall_needs_row_end: assert property (@(posedge clk) disable iff (rst)
    stall |-> s3_tag.eor && out_valid)
    else $error("stall without a pending row result");
`endif

endmodule

// ----- test/dmvm_row_checker.sv -----
// Row checker for the dequantizing matrix-vector MAC: tracks config writes and
// accepted input items, predicts each row item and compares it with the output.
// Depends on dmvm_pkg.
`timescale 1ns / 1ps

module dmvm_row_checker #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [dmvm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [dmvm_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic                                    op,
  input  logic [dmvm_pkg::VEC_IDX_W-1:0]          vec_index,
  input  logic signed [dmvm_pkg::DATA_W-1:0]      vec_value,
  input  logic signed [dmvm_pkg::DATA_W-1:0]      weight_value,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [dmvm_pkg::ACC_W-1:0]       row_sum,
  input  logic [dmvm_pkg::ROW_NUM_W-1:0]          row_number,
  input  logic                                    last_row,
  input  logic                                    saturated,
  output int                                      fail_count,
  output int                                      rows_pending
);

  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic signed [dmvm_pkg::ACC_W-1:0] sum;
    logic [dmvm_pkg::ROW_NUM_W-1:0]    row;
    logic                              last;
    logic                              sat;
  } row_result_t;

  // shadow copy of the configuration registers
  logic                               weight_mode;
  logic [dmvm_pkg::LEN_REG_W-1:0]     row_length;
  logic [dmvm_pkg::LEN_REG_W-1:0]     row_count;
  logic signed [dmvm_pkg::DATA_W-1:0] weight_base;
  logic [dmvm_pkg::DATA_W-1:0]        weight_scale;

  logic signed [dmvm_pkg::DATA_W-1:0] vec_mem [MAX_COLS];
  longint      dot_acc;
  int          col_pos;
  int          row_pos;
  bit          sat_seen;
  row_result_t rows_due [$];
  int          mismatch_count = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] row item mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : track
    longint      wt;
    longint      biased;
    longint      sum;
    int          cols;
    int          rows;
    row_result_t due;

    if (rst) begin
      weight_mode  = 1'b0;
      row_length   = 11'd1024;
      row_count    = 11'd1;
      weight_base  = '0;
      weight_scale = 16'd4096;
      dot_acc      = 0;
      col_pos      = 0;
      row_pos      = 0;
      sat_seen     = 1'b0;
      rows_due.delete();
    end else begin
      // retire before predicting: an output can never belong to this edge's item
      if (out_valid && out_ready) begin
        if (rows_due.size() == 0) begin
          report_mismatch($sformatf("unexpected row item, row_number %0d sum %0d",
                                    row_number, row_sum));
        end else begin
          due = rows_due.pop_front();
          if (row_sum !== due.sum)
            report_mismatch($sformatf("row %0d: row_sum %0d, predicted %0d",
                                      due.row, row_sum, $signed(due.sum)));
          if (row_number !== due.row)
            report_mismatch($sformatf("row_number %0d, predicted %0d", row_number, due.row));
          if (last_row !== due.last)
            report_mismatch($sformatf("row %0d: last_row %b, predicted %b",
                                      due.row, last_row, due.last));
          if (saturated !== due.sat)
            report_mismatch($sformatf("row %0d: saturated %b, predicted %b",
                                      due.row, saturated, due.sat));
        end
      end

      if (in_valid && in_ready) begin
        if (op == dmvm_pkg::OP_LOAD) begin
          vec_mem[int'(vec_index) % MAX_COLS] = vec_value;
        end else begin
          cols = (row_length == 0) ? 1 :
                 (row_length > MAX_COLS) ? MAX_COLS : int'(row_length);
          rows = (row_count == 0) ? 1 :
                 (row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count);
          if (weight_mode) begin
            // Q.12 sum, round half up to Q8.8; only the low byte is the code
            biased = longint'(weight_base) * 16 +
                     longint'(weight_scale) * longint'(weight_value[7:0]) + 8;
            wt = biased >>> 4;
            if (wt > 32767) begin
              wt = 32767;
              sat_seen = 1'b1;
            end else if (wt < -32768) begin
              wt = -32768;
              sat_seen = 1'b1;
            end
          end else begin
            wt = longint'(weight_value);
          end
          sum = dot_acc + wt * longint'(vec_mem[col_pos]);
          if (sum > SUM_MAX) begin
            sum = SUM_MAX;
            sat_seen = 1'b1;
          end else if (sum < SUM_MIN) begin
            sum = SUM_MIN;
            sat_seen = 1'b1;
          end
          dot_acc = sum;
          // >= so that a length shrunk mid-row ends the row at once
          if (col_pos + 1 < cols) begin
            col_pos++;
          end else begin
            due.sum  = dot_acc[dmvm_pkg::ACC_W-1:0];
            due.row  = row_pos[dmvm_pkg::ROW_NUM_W-1:0];
            due.last = (row_pos + 1 >= rows);
            due.sat  = sat_seen;
            rows_due.push_back(due);
            dot_acc  = 0;
            col_pos  = 0;
            sat_seen = 1'b0;
            row_pos  = due.last ? 0 : row_pos + 1;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          dmvm_pkg::REG_WEIGHT_MODE:  weight_mode  = cfg_data[0];
          dmvm_pkg::REG_ROW_LENGTH:   row_length   = cfg_data[dmvm_pkg::LEN_REG_W-1:0];
          dmvm_pkg::REG_ROW_COUNT:    row_count    = cfg_data[dmvm_pkg::LEN_REG_W-1:0];
          dmvm_pkg::REG_WEIGHT_BASE:  weight_base  = cfg_data;
          dmvm_pkg::REG_WEIGHT_SCALE: weight_scale = cfg_data;
          default: ;
        endcase
      end
    end
    rows_pending <= rows_due.size();
    fail_count   <= mismatch_count;
  end

endmodule

// ----- test/tb_dequant_matrix_vector_mac.sv -----
// Testbench top for the dequantizing matrix-vector MAC: clock, reset, config
// writes, input items and output back-pressure; verdict from dmvm_row_checker.
// Depends on dmvm_pkg, dequant_matrix_vector_mac and dmvm_row_checker.
`timescale 1ns / 1ps

module tb_dequant_matrix_vector_mac;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  // entries reached by the longest rows the test configures
  localparam int USED_ENTRIES = 40;

  logic                                clk;
  logic                                rst          = 1'b1;
  logic                                cfg_we       = 1'b0;
  logic [dmvm_pkg::CFG_IDX_W-1:0]      cfg_index    = '0;
  logic [dmvm_pkg::CFG_DATA_W-1:0]     cfg_data     = '0;
  logic                                in_valid     = 1'b0;
  logic                                in_ready;
  logic                                op           = 1'b0;
  logic [dmvm_pkg::VEC_IDX_W-1:0]      vec_index    = '0;
  logic signed [dmvm_pkg::DATA_W-1:0]  vec_value    = '0;
  logic signed [dmvm_pkg::DATA_W-1:0]  weight_value = '0;
  logic                                out_valid;
  logic                                out_ready    = 1'b0;
  logic signed [dmvm_pkg::ACC_W-1:0]   row_sum;
  logic [dmvm_pkg::ROW_NUM_W-1:0]      row_number;
  logic                                last_row;
  logic                                saturated;

  int fail_count;
  int rows_pending;
  int send_idle   = 0;
  int recv_stall  = 0;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int cycle_count = 0;

  dequant_matrix_vector_mac u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .op, .vec_index, .vec_value, .weight_value,
    .out_valid, .out_ready, .row_sum, .row_number, .last_row, .saturated
  );

  dmvm_row_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .op, .vec_index, .vec_value, .weight_value,
    .out_valid, .out_ready, .row_sum, .row_number, .last_row, .saturated,
    .fail_count, .rows_pending
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // output back-pressure; a bump of hold_req starts one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_item(dmvm_pkg::op_t kind, logic [dmvm_pkg::VEC_IDX_W-1:0] idx,
                           logic signed [dmvm_pkg::DATA_W-1:0] val,
                           logic signed [dmvm_pkg::DATA_W-1:0] wt);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    vec_index    <= idx;
    vec_value    <= val;
    weight_value <= wt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_entry(int idx, int val);
    send_item(dmvm_pkg::OP_LOAD, dmvm_pkg::VEC_IDX_W'(idx), dmvm_pkg::DATA_W'(val),
              dmvm_pkg::DATA_W'($urandom));
  endtask

  task automatic send_weight(int wt);
    send_item(dmvm_pkg::OP_WEIGHT, dmvm_pkg::VEC_IDX_W'($urandom),
              dmvm_pkg::DATA_W'($urandom), dmvm_pkg::DATA_W'(wt));
  endtask

  // wait until every row item is out, plus the pipeline depth for partial rows
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [dmvm_pkg::CFG_IDX_W-1:0] idx, int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dmvm_pkg::CFG_DATA_W'(data);
    @(posedge clk);
  endtask

  task automatic write_regs(logic mode, int len, int cnt, int base, int scale);
    settle();
    write_reg(dmvm_pkg::REG_WEIGHT_MODE, int'(mode));
    write_reg(dmvm_pkg::REG_ROW_LENGTH, len);
    write_reg(dmvm_pkg::REG_ROW_COUNT, cnt);
    write_reg(dmvm_pkg::REG_WEIGHT_BASE, base);
    write_reg(dmvm_pkg::REG_WEIGHT_SCALE, scale);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_len();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(7, USED_ENTRIES);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int pick_count();
    case ($urandom_range(9))
      0: return 0;
      1: return 2047;
      default: return $urandom_range(1, 5);
    endcase
  endfunction

  function automatic int pick_base();
    case ($urandom_range(5))
      0: return -32768;
      1: return 32767;
      2: return int'($urandom_range(1024)) - 512;
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic int pick_scale();
    case ($urandom_range(5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(8192);
      default: return $urandom_range(65535);
    endcase
  endfunction

  initial begin
    int random_items;
    int phase;
    int burst;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // raw extremes over two rows
    write_regs(1'b0, 4, 2, 0, 4096);
    load_entry(0, 32767);
    load_entry(1, -32768);
    load_entry(2, 1);
    load_entry(3, -1);
    send_weight(32767);
    send_weight(-32768);
    send_weight(32767);
    send_weight(-32768);
    send_weight(-32768);
    send_weight(32767);
    send_weight(0);
    send_weight(1);

    // quantized: low byte only, lowest base, then weight saturation
    write_regs(1'b1, 2, 1, -32768, 65535);
    send_weight(16'hFF00);
    send_weight(16'h80FF);
    write_regs(1'b1, 2, 1, 32767, 65535);
    send_weight(255);
    send_weight(16'h7F01);

    // shrink row length mid-row, load mid-row, then shrink row count mid-pass
    write_regs(1'b0, 4, 4, 0, 4096);
    send_weight(300);
    load_entry(1, 1234);
    send_weight(-7);
    send_weight(512);
    write_regs(1'b0, 2, 4, 0, 4096);
    send_weight(99);
    send_weight(-1);
    send_weight(2);
    send_weight(3);
    send_weight(4);
    write_regs(1'b0, 2, 1, 0, 4096);
    send_weight(5);
    send_weight(6);

    // zero length and zero count act as one
    write_regs(1'b0, 0, 0, 0, 4096);
    send_weight(-32768);
    send_weight(77);

    // oversize length keeps the row open until a shrink ends it
    for (int i = 4; i < USED_ENTRIES; i++)
      load_entry(i, $urandom);
    write_regs(1'b0, 2047, 0, 0, 4096);
    repeat (20) send_weight($urandom);
    write_regs(1'b1, 1, 1, pick_base(), pick_scale());
    send_weight($urandom);

    // long receiver hold-off while the sender keeps pushing
    recv_stall <= 0;
    write_regs(1'b0, 1, 7, 0, 4096);
    hold_req <= hold_req + 1;
    repeat (40) send_weight($urandom);

    random_items = 0;
    phase = 0;
    while (random_items < 275) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall <= 0;  end
        1: begin send_idle = 57; recv_stall <= 0;  end
        2: begin send_idle = 0;  recv_stall <= 57; end
        default: begin send_idle = 15; recv_stall <= 15; end
      endcase
      write_regs(1'($urandom_range(1)), pick_len(), pick_count(), pick_base(),
                 pick_scale());
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        if ($urandom_range(99) < 15)
          load_entry($urandom, $urandom);
        else
          send_weight($urandom);
      end
      random_items += burst;
      phase++;
    end

    settle();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
